>>> rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int IN_W  = 16;
  localparam int OUT_W = 15;

  // 1/sqrt2 with 31 fraction bits; scaled down to the working precision.
  localparam longint unsigned INV_SQRT2_Q31 = 64'd1518500250;

  typedef struct packed {
    logic signed [IN_W-1:0] p_w;
    logic signed [IN_W-1:0] p_x;
    logic signed [IN_W-1:0] p_y;
    logic signed [IN_W-1:0] p_z;
    logic signed [IN_W-1:0] q_w;
    logic signed [IN_W-1:0] q_x;
    logic signed [IN_W-1:0] q_y;
    logic signed [IN_W-1:0] q_z;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] dis_w;
    logic [OUT_W-1:0] dis_x;
    logic [OUT_W-1:0] dis_y;
    logic [OUT_W-1:0] dis_z;
  } out_t;

endpackage

>>> rtl/cdq_rel.sv
module cdq_rel
  import cdq_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  localparam int RW = 35 - FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_t                   in_data,
  output logic                  r_valid,
  output logic [3:0][RW-1:0]    r_data
);

  localparam int PW = 2 * IN_W;
  localparam int SW = PW + 2;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic signed [IN_W-1:0] pv [4];
  logic signed [IN_W-1:0] qv [4];

  logic signed [PW-1:0] prod_nxt [4][4];
  logic signed [PW-1:0] prod_r   [4][4];
  logic signed [SW-1:0] sum_nxt  [4];
  logic signed [SW-1:0] sum_r    [4];
  logic        [SW-1:0] mag      [4];
  logic        [SW-1:0] rnd      [4];
  logic [3:0][RW-1:0]   r_nxt;
  logic [3:0][RW-1:0]   r_r;
  logic [2:0]           vld_r;

  assign pv[0] = in_data.p_w;
  assign pv[1] = in_data.p_x;
  assign pv[2] = in_data.p_y;
  assign pv[3] = in_data.p_z;
  assign qv[0] = in_data.q_w;
  assign qv[1] = in_data.q_x;
  assign qv[2] = in_data.q_y;
  assign qv[3] = in_data.q_z;

  // Element [i][j] holds q_i * p_j.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = qv[i] * pv[j];
      end
    end
  end

  // Components of conj(q) * p at full precision.
  always_comb begin
    sum_nxt[0] = SW'(prod_r[0][0]) + SW'(prod_r[1][1]) + SW'(prod_r[2][2])
               + SW'(prod_r[3][3]);
    sum_nxt[1] = SW'(prod_r[0][1]) - SW'(prod_r[1][0]) + SW'(prod_r[3][2])
               - SW'(prod_r[2][3]);
    sum_nxt[2] = SW'(prod_r[0][2]) - SW'(prod_r[2][0]) - SW'(prod_r[3][1])
               + SW'(prod_r[1][3]);
    sum_nxt[3] = SW'(prod_r[0][3]) - SW'(prod_r[3][0]) + SW'(prod_r[2][1])
               - SW'(prod_r[1][2]);
  end

  // Rounding on the magnitude gives ties away from zero.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k]   = sum_r[k][SW-1] ? SW'(-sum_r[k]) : SW'(sum_r[k]);
      rnd[k]   = (mag[k] + HALF) >> FRAC_BITS;
      r_nxt[k] = sum_r[k][SW-1] ? -RW'(rnd[k]) : RW'(rnd[k]);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    r_r    <= r_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  assign r_valid = vld_r[2];
  assign r_data  = r_r;

endmodule

>>> rtl/cdq_sym.sv
module cdq_sym
  import cdq_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  localparam int RW = 35 - FRAC_BITS,
  localparam int MW = 34 - FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  r_valid,
  input  logic [3:0][RW-1:0]    r_data,
  output logic                  mag_valid,
  output logic [23:0][MW-1:0]   mag_data
);

  localparam int PRW = RW + 1;
  localparam int QW  = RW + 2;
  localparam int KW  = FRAC_BITS + 1;
  localparam int KPW = PRW + KW;
  localparam longint unsigned K_VAL =
    (INV_SQRT2_Q31 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
  localparam logic signed [KW-1:0] K_S = KW'(K_VAL);
  localparam logic [KPW-1:0] HALF = KPW'(1) << (FRAC_BITS - 1);

  logic signed [RW-1:0]  rv [4];
  logic signed [PRW-1:0] pr_nxt [12];
  logic signed [PRW-1:0] pr_r   [12];
  logic signed [QW-1:0]  qd_nxt [8];
  logic signed [QW-1:0]  qd_r   [8];
  logic signed [RW-1:0]  r_r    [4];

  logic signed [KPW-1:0] pk_nxt [12];
  logic signed [KPW-1:0] pk_r   [12];
  logic        [QW-1:0]  qabs   [8];
  logic        [RW-1:0]  rabs   [4];
  logic        [MW-1:0]  qm_nxt [8];
  logic        [MW-1:0]  qm_r   [8];
  logic        [MW-1:0]  rm_nxt [4];
  logic        [MW-1:0]  rm_r   [4];

  logic        [KPW-1:0] pabs   [12];
  logic [23:0][MW-1:0]   mag_nxt;
  logic [23:0][MW-1:0]   mag_r;
  logic [2:0]            vld_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rv[k] = r_data[k];
    end
  end

  // Pair sums of the first three variants and the quad sums of the next two.
  always_comb begin
    pr_nxt[0]  = PRW'(rv[0]) + PRW'(rv[1]);
    pr_nxt[1]  = PRW'(rv[0]) - PRW'(rv[1]);
    pr_nxt[2]  = PRW'(rv[2]) + PRW'(rv[3]);
    pr_nxt[3]  = PRW'(rv[2]) - PRW'(rv[3]);
    pr_nxt[4]  = PRW'(rv[0]) + PRW'(rv[2]);
    pr_nxt[5]  = PRW'(rv[0]) - PRW'(rv[2]);
    pr_nxt[6]  = PRW'(rv[1]) + PRW'(rv[3]);
    pr_nxt[7]  = PRW'(rv[1]) - PRW'(rv[3]);
    pr_nxt[8]  = PRW'(rv[0]) + PRW'(rv[3]);
    pr_nxt[9]  = PRW'(rv[0]) - PRW'(rv[3]);
    pr_nxt[10] = PRW'(rv[1]) + PRW'(rv[2]);
    pr_nxt[11] = PRW'(rv[1]) - PRW'(rv[2]);
    qd_nxt[0]  = QW'(rv[0]) + QW'(rv[1]) + QW'(rv[2]) + QW'(rv[3]);
    qd_nxt[1]  = QW'(rv[0]) + QW'(rv[1]) - QW'(rv[2]) - QW'(rv[3]);
    qd_nxt[2]  = QW'(rv[0]) - QW'(rv[1]) + QW'(rv[2]) - QW'(rv[3]);
    qd_nxt[3]  = QW'(rv[0]) - QW'(rv[1]) - QW'(rv[2]) + QW'(rv[3]);
    qd_nxt[4]  = QW'(rv[0]) + QW'(rv[1]) + QW'(rv[2]) - QW'(rv[3]);
    qd_nxt[5]  = QW'(rv[0]) + QW'(rv[1]) - QW'(rv[2]) + QW'(rv[3]);
    qd_nxt[6]  = QW'(rv[0]) - QW'(rv[1]) + QW'(rv[2]) + QW'(rv[3]);
    qd_nxt[7]  = QW'(rv[0]) - QW'(rv[1]) - QW'(rv[2]) - QW'(rv[3]);
  end

  // Only magnitudes are needed from here on, so the halving is done on them.
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      pk_nxt[k] = pr_r[k] * K_S;
    end
    for (int k = 0; k < 8; k++) begin
      qabs[k]   = qd_r[k][QW-1] ? QW'(-qd_r[k]) : QW'(qd_r[k]);
      qm_nxt[k] = MW'((qabs[k] + QW'(1)) >> 1);
    end
    for (int k = 0; k < 4; k++) begin
      rabs[k]   = r_r[k][RW-1] ? RW'(-r_r[k]) : RW'(r_r[k]);
      rm_nxt[k] = MW'(rabs[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      pabs[k]    = pk_r[k][KPW-1] ? KPW'(-pk_r[k]) : KPW'(pk_r[k]);
      mag_nxt[k] = MW'((pabs[k] + HALF) >> FRAC_BITS);
    end
    for (int k = 0; k < 8; k++) begin
      mag_nxt[12 + k] = qm_r[k];
    end
    for (int k = 0; k < 4; k++) begin
      mag_nxt[20 + k] = rm_r[k];
    end
  end

  always_ff @(posedge clk) begin
    pr_r  <= pr_nxt;
    qd_r  <= qd_nxt;
    r_r   <= rv;
    pk_r  <= pk_nxt;
    qm_r  <= qm_nxt;
    rm_r  <= rm_nxt;
    mag_r <= mag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], r_valid};
    end
  end

  assign mag_valid = vld_r[2];
  assign mag_data  = mag_r;

endmodule

>>> rtl/cdq_pick.sv
module cdq_pick
  import cdq_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  localparam int MW = 34 - FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mag_valid,
  input  logic [23:0][MW-1:0]   mag_data,
  output logic                  out_valid,
  output out_t                  out_data
);

  localparam int SATW = FRAC_BITS + 1;
  localparam int CW   = (MW > SATW) ? MW : SATW;
  localparam logic [CW-1:0] ONE_Q = CW'(1) << FRAC_BITS;

  logic [23:0][MW-1:0] mag7_r;
  logic [MW-1:0]       m01a, m01b, m23a, m23b;
  logic [MW-1:0]       vmax_nxt [6];
  logic [MW-1:0]       vmax_r   [6];

  logic [MW-1:0]       t01, t23, t45, t03;
  logic [2:0]          i01, i23, i45, i03, iall;
  logic [2:0]          pick_r;
  logic [23:0][MW-1:0] mag8_r;

  logic [4:0]          sel      [4];
  logic [CW-1:0]       mext     [4];
  logic [SATW-1:0]     sat_nxt  [4];
  logic [SATW-1:0]     sat_r    [4];

  logic [SATW-1:0]     t1 [4];
  logic [SATW-1:0]     t2 [4];
  logic [SATW-1:0]     t3 [4];
  out_t                out_nxt;
  out_t                out_r;
  logic [3:0]          vld_r;

  // Largest magnitude within each variant.
  always_comb begin
    for (int v = 0; v < 6; v++) begin
      m01a = mag_data[4*v];
      m01b = mag_data[4*v + 1];
      m23a = mag_data[4*v + 2];
      m23b = mag_data[4*v + 3];
      m01a = (m01a >= m01b) ? m01a : m01b;
      m23a = (m23a >= m23b) ? m23a : m23b;
      vmax_nxt[v] = (m01a >= m23a) ? m01a : m23a;
    end
  end

  // The lower variant keeps ties, so the first maximal component wins and an
  // all-zero item falls to variant zero.
  always_comb begin
    if (vmax_r[0] >= vmax_r[1]) begin
      t01 = vmax_r[0]; i01 = 3'd0;
    end else begin
      t01 = vmax_r[1]; i01 = 3'd1;
    end
    if (vmax_r[2] >= vmax_r[3]) begin
      t23 = vmax_r[2]; i23 = 3'd2;
    end else begin
      t23 = vmax_r[3]; i23 = 3'd3;
    end
    if (vmax_r[4] >= vmax_r[5]) begin
      t45 = vmax_r[4]; i45 = 3'd4;
    end else begin
      t45 = vmax_r[5]; i45 = 3'd5;
    end
    if (t01 >= t23) begin
      t03 = t01; i03 = i01;
    end else begin
      t03 = t23; i03 = i23;
    end
    if (t03 >= t45) begin
      iall = i03;
    end else begin
      iall = i45;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sel[j]     = {pick_r, 2'(j)};
      mext[j]    = CW'(mag8_r[sel[j]]);
      sat_nxt[j] = (mext[j] > ONE_Q) ? SATW'(ONE_Q) : SATW'(mext[j]);
    end
  end

  // Four-input sorting network, largest first.
  always_comb begin
    t1[0] = (sat_r[0] >= sat_r[1]) ? sat_r[0] : sat_r[1];
    t1[1] = (sat_r[0] >= sat_r[1]) ? sat_r[1] : sat_r[0];
    t1[2] = (sat_r[2] >= sat_r[3]) ? sat_r[2] : sat_r[3];
    t1[3] = (sat_r[2] >= sat_r[3]) ? sat_r[3] : sat_r[2];
    t2[0] = (t1[0] >= t1[2]) ? t1[0] : t1[2];
    t2[2] = (t1[0] >= t1[2]) ? t1[2] : t1[0];
    t2[1] = (t1[1] >= t1[3]) ? t1[1] : t1[3];
    t2[3] = (t1[1] >= t1[3]) ? t1[3] : t1[1];
    t3[0] = t2[0];
    t3[1] = (t2[1] >= t2[2]) ? t2[1] : t2[2];
    t3[2] = (t2[1] >= t2[2]) ? t2[2] : t2[1];
    t3[3] = t2[3];
    out_nxt.dis_w = OUT_W'(t3[0]);
    out_nxt.dis_x = OUT_W'(t3[1]);
    out_nxt.dis_y = OUT_W'(t3[2]);
    out_nxt.dis_z = OUT_W'(t3[3]);
  end

  always_ff @(posedge clk) begin
    mag7_r <= mag_data;
    vmax_r <= vmax_nxt;
    mag8_r <= mag7_r;
    pick_r <= iall;
    sat_r  <= sat_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], mag_valid};
    end
  end

  assign out_valid = vld_r[3];
  assign out_data  = out_r;

endmodule

>>> rtl/cubic_disorientation_quaternion_unit.sv
// Channel   Direction  Handshake             Payload
// input     in         start, busy           in_data  (in_t: p_w .. q_z)
// result    out        out_valid (strobe)    out_data (out_t: dis_w .. dis_z)
//
// One item is taken in every cycle; busy is held low, as nothing inside stalls.
// Each result passes through ten register stages: three for the quaternion product,
// three for the symmetry variants and four for the pick, saturation and sort.
// Reset clears only the valid bits of the stages.
// The result is shown for one cycle with out_valid high and is not held.
module cubic_disorientation_quaternion_unit
  import cdq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int RW = 35 - FRAC_BITS;
  localparam int MW = 34 - FRAC_BITS;

  logic                in_acc;
  logic                r_valid;
  logic [3:0][RW-1:0]  r_data;
  logic                mag_valid;
  logic [23:0][MW-1:0] mag_data;

  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  cdq_rel #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rel (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_acc),
    .in_data  (in_data),
    .r_valid  (r_valid),
    .r_data   (r_data)
  );

  cdq_sym #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sym (
    .clk       (clk),
    .rst_n     (rst_n),
    .r_valid   (r_valid),
    .r_data    (r_data),
    .mag_valid (mag_valid),
    .mag_data  (mag_data)
  );

  cdq_pick #(
    .FRAC_BITS (FRAC_BITS)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .mag_valid (mag_valid),
    .mag_data  (mag_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import cdq_pkg::*;

  localparam int     FB          = 14;
  localparam longint ONE_Q       = longint'(1) << FB;
  localparam longint K_INV_SQRT2 =
    (longint'(INV_SQRT2_Q31) + (longint'(1) << (30 - FB))) >>> (31 - FB);
  localparam int     RAND_PER_PHASE = 510;

  typedef enum int {STYLE_UNIFORM, STYLE_ANCHOR, STYLE_SMALL} stim_style_t;

  typedef struct {
    in_t  stim;
    bit   known;
    out_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  out_t     dis_expected[$];
  dir_row_t dir_rows[$];
  int       err_count;
  int       items_sent;
  int       results_seen;
  int       dir_count;

  cubic_disorientation_quaternion_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  // Divide by 2^s, rounding to nearest with ties away from zero.
  function automatic longint round_away(longint v, int s);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint scale_k(longint v);
    return round_away(v * K_INV_SQRT2, FB);
  endfunction

  function automatic out_t predict_disorientation(in_t it);
    longint pw, px, py, pz, qw, qx, qy, qz;
    longint a, b, c, d;
    longint var_c[6][4];
    longint best;
    longint m;
    longint srt[4];
    longint t;
    int     pick;
    out_t   res;
    pw = longint'($signed(it.p_w));
    px = longint'($signed(it.p_x));
    py = longint'($signed(it.p_y));
    pz = longint'($signed(it.p_z));
    qw = longint'($signed(it.q_w));
    qx = longint'($signed(it.q_x));
    qy = longint'($signed(it.q_y));
    qz = longint'($signed(it.q_z));

    // Relative rotation conj(q) * p, rounded once per component.
    a = round_away(qw * pw + qx * px + qy * py + qz * pz, FB);
    b = round_away(-qx * pw + qw * px + qz * py - qy * pz, FB);
    c = round_away(-qy * pw - qz * px + qw * py + qx * pz, FB);
    d = round_away(-qz * pw + qy * px - qx * py + qw * pz, FB);

    var_c[0] = '{scale_k(a + b), scale_k(a - b), scale_k(c + d), scale_k(c - d)};
    var_c[1] = '{scale_k(a + c), scale_k(a - c), scale_k(b + d), scale_k(b - d)};
    var_c[2] = '{scale_k(a + d), scale_k(a - d), scale_k(b + c), scale_k(b - c)};
    var_c[3] = '{round_away(a + b + c + d, 1), round_away(a + b - c - d, 1),
                 round_away(a - b + c - d, 1), round_away(a - b - c + d, 1)};
    var_c[4] = '{round_away(a + b + c - d, 1), round_away(a + b - c + d, 1),
                 round_away(a - b + c + d, 1), round_away(a - b - c - d, 1)};
    var_c[5] = '{a, b, c, d};

    // Only a strictly larger magnitude moves the pick, so the first maximum wins.
    best = 0;
    pick = 0;
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 4; j++) begin
        m = (var_c[i][j] < 0) ? -var_c[i][j] : var_c[i][j];
        if (m > best) begin
          best = m;
          pick = i;
        end
      end
    end

    for (int j = 0; j < 4; j++) begin
      m = (var_c[pick][j] < 0) ? -var_c[pick][j] : var_c[pick][j];
      srt[j] = (m > ONE_Q) ? ONE_Q : m;
    end

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3 - i; j++) begin
        if (srt[j] < srt[j + 1]) begin
          t = srt[j];
          srt[j] = srt[j + 1];
          srt[j + 1] = t;
        end
      end
    end

    res.dis_w = srt[0][OUT_W-1:0];
    res.dis_x = srt[1][OUT_W-1:0];
    res.dis_y = srt[2][OUT_W-1:0];
    res.dis_z = srt[3][OUT_W-1:0];
    return res;
  endfunction

  function automatic in_t mk_in(int pw, int px, int py, int pz,
                                int qw, int qx, int qy, int qz);
    in_t it;
    it.p_w = pw[IN_W-1:0];
    it.p_x = px[IN_W-1:0];
    it.p_y = py[IN_W-1:0];
    it.p_z = pz[IN_W-1:0];
    it.q_w = qw[IN_W-1:0];
    it.q_x = qx[IN_W-1:0];
    it.q_y = qy[IN_W-1:0];
    it.q_z = qz[IN_W-1:0];
    return it;
  endfunction

  function automatic out_t mk_out(int w, int x, int y, int z);
    out_t o;
    o.dis_w = w[OUT_W-1:0];
    o.dis_x = x[OUT_W-1:0];
    o.dis_y = y[OUT_W-1:0];
    o.dis_z = z[OUT_W-1:0];
    return o;
  endfunction

  function automatic logic [IN_W-1:0] rand_comp(stim_style_t style);
    int anchors[9] = '{0, 8192, -8192, 11585, -11585, 16384, -16384, 1, -1};
    int v;
    case (style)
      STYLE_UNIFORM: begin
        v = int'($urandom_range(32768)) - 16384;
      end
      STYLE_ANCHOR: begin
        v = anchors[$urandom_range(8)];
        if ($urandom_range(1) == 1) v = v + int'($urandom_range(8)) - 4;
      end
      default: begin
        v = int'($urandom_range(64)) - 32;
      end
    endcase
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[IN_W-1:0];
  endfunction

  function automatic in_t rand_item();
    stim_style_t style;
    int          sel;
    in_t         it;
    sel = int'($urandom_range(99));
    style = (sel < 55) ? STYLE_UNIFORM : (sel < 90) ? STYLE_ANCHOR : STYLE_SMALL;
    it.p_w = rand_comp(style);
    it.p_x = rand_comp(style);
    it.p_y = rand_comp(style);
    it.p_z = rand_comp(style);
    it.q_w = rand_comp(style);
    it.q_x = rand_comp(style);
    it.q_y = rand_comp(style);
    it.q_z = rand_comp(style);
    return it;
  endfunction

  // start stays high between back-to-back items; it is only lowered for a gap.
  task automatic send_item(input in_t item, input bit known, input out_t want,
                           input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    dis_expected.push_back(known ? want : predict_disorientation(item));
    items_sent++;
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (dis_expected.size() == 0) begin
        $error("result arrived with no item outstanding");
        err_count++;
      end else begin
        want = dis_expected.pop_front();
        check_field("dis_w", want.dis_w, out_data.dis_w);
        check_field("dis_x", want.dis_x, out_data.dis_x);
        check_field("dis_y", want.dis_y, out_data.dis_y);
        check_field("dis_z", want.dis_z, out_data.dis_z);
      end
    end
  end

  initial begin
    out_t none;
    int   phase_idle[3] = '{10, 59, 0};
    none         = '0;
    err_count    = 0;
    items_sent   = 0;
    results_seen = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;

    // Typed expectations are the cases that read off directly; the rest use the predictor.
    dir_rows.push_back(dir_row_t'{mk_in(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{mk_in(16384, 0, 0, 0, 16384, 0, 0, 0), 1'b1,
                                  mk_out(16384, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{mk_in(-16384, 0, 0, 0, 16384, 0, 0, 0), 1'b1,
                                  mk_out(16384, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{mk_in(16384, 16384, 16384, 16384, 16384, 0, 0, 0), 1'b1,
                                  mk_out(16384, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{mk_in(-16384, -16384, -16384, -16384,
                                        16384, 16384, 16384, 16384), 1'b1,
                                  mk_out(16384, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{mk_in(8192, 8192, 8192, 8192, 16384, 0, 0, 0), 1'b1,
                                  mk_out(16384, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{mk_in(16384, -16384, 16384, -16384,
                                        -16384, 16384, -16384, 16384), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(11585, 11585, 0, 0, 16384, 0, 0, 0), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(11585, 0, 11585, 0, 16384, 0, 0, 0), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(11585, 0, 0, 11585, 16384, 0, 0, 0), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(1, 0, 0, 0, 8192, 0, 0, 0), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(1, 0, 0, 0, -8192, 0, 0, 0), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(16384, 0, 0, 0, 0, 16384, 0, 0), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(0, 0, 0, 16384, 0, 0, 16384, 0), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(-16384, 16384, -1, 1, 1, -1, 16384, -16384),
                                  1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(16384, 16384, -16384, -16384,
                                        16384, -16384, 16384, -16384), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(16383, -16383, 10922, -5461,
                                        5461, -10922, 16383, -16383), 1'b0, none});
    dir_rows.push_back(dir_row_t'{mk_in(8191, 8193, -8191, -8193,
                                        12345, -3, 7, -9999), 1'b0, none});
    dir_count = dir_rows.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].want, phase_idle[0]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        send_item(rand_item(), 1'b0, none, phase_idle[ph]);
      end
    end
    start <= 1'b0;

    while (dis_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("summary: %0d directed and %0d random quaternion pairs sent, %0d results checked",
             dir_count, items_sent - dir_count, results_seen);
    $display("summary: sender gaps of 10, 59 and 0 percent; %0d mismatches", err_count);
    if (err_count == 0 && dis_expected.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cdq_pkg.sv
rtl/cdq_rel.sv
rtl/cdq_sym.sv
rtl/cdq_pick.sv
rtl/cubic_disorientation_quaternion_unit.sv
tb/sv/testbench.sv
